// File: design/stsu_pkg.sv
// Shared types and constants for the sorted table insert/remove/search unit.
// No dependencies; used by the channel interfaces, controller, datapath and top level.
`default_nettype none

package stsu_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int OP_W         = 2;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 7;
    localparam int SAT_MAX      = 127;

    typedef enum logic [OP_W-1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    // read address source
    typedef enum logic [2:0] {
        RD_MID    = 3'd0,
        RD_POS    = 3'd1,
        RD_POS_M1 = 3'd2,
        RD_POS_M2 = 3'd3,
        RD_POS_P1 = 3'd4,
        RD_POS_P2 = 3'd5
    } rd_sel_t;

    // write data source, address is always the position register
    typedef enum logic {
        WR_KEY  = 1'b0,
        WR_DATA = 1'b1
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    pos_inc;
        logic    pos_dec;
        logic    iter_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_found;
        logic    mid_capture;
        logic    lo_up;
        logic    hi_down;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            search_open;
        logic            cmp_eq;
        logic            cmp_lt;
        logic            cmp_gt;
        logic            pos_zero;
        logic            pos_one;
        logic            pos_lt_count;
        logic            pos1_lt_count;
        logic            pos2_lt_count;
        logic            out_busy;
    } status_t;

endpackage

`default_nettype wire

// File: design/stsu_req_if.sv
// Request channel: operation code and key, with valid/ready handshake.
// Depends on stsu_pkg for field widths.
`default_nettype none

interface stsu_req_if;
    logic                                valid;
    logic                                ready;
    logic [stsu_pkg::OP_W-1:0]           operation;
    logic signed [stsu_pkg::VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

// File: design/stsu_rsp_if.sv
// Response channel: iteration count, flags and entry count, with valid/ready handshake.
// Depends on stsu_pkg for field widths.
`default_nettype none

interface stsu_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [stsu_pkg::COUNT_OUT_W-1:0]  iterations;
    logic                              found;
    logic                              dropped;
    logic [stsu_pkg::COUNT_OUT_W-1:0]  entry_count;

    modport source (output valid, output iterations, output found, output dropped,
                    output entry_count, input ready);
    modport sink   (input valid, input iterations, input found, input dropped,
                    input entry_count, output ready);
endinterface

`default_nettype wire

// File: design/stsu_ctrl.sv
// Controller state machine: sequences search probes, insert shifts and remove scan/shift.
// Depends on stsu_pkg for the command and status structs.
`default_nettype none

module stsu_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire stsu_pkg::status_t status,
    output stsu_pkg::cmd_t         cmd
);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_DISPATCH  = 10'b0000000010,
        ST_SR_ISSUE  = 10'b0000000100,
        ST_SR_CMP    = 10'b0000001000,
        ST_INS_ISSUE = 10'b0000010000,
        ST_INS_STEP  = 10'b0000100000,
        ST_RM_ISSUE  = 10'b0001000000,
        ST_RM_SCAN   = 10'b0010000000,
        ST_RM_SHIFT  = 10'b0100000000,
        ST_DONE      = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = stsu_pkg::RD_POS;
        cmd.wr_sel = stsu_pkg::WR_KEY;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.op)
                    stsu_pkg::OP_SEARCH: state_next = ST_SR_ISSUE;
                    stsu_pkg::OP_INSERT: state_next = status.full ? ST_DONE : ST_INS_ISSUE;
                    stsu_pkg::OP_REMOVE: state_next = ST_RM_ISSUE;
                    default:             state_next = ST_DONE;
                endcase
            end
            ST_SR_ISSUE:
            begin
                if (status.search_open)
                begin
                    cmd.rd_en       = 1'b1;
                    cmd.rd_sel      = stsu_pkg::RD_MID;
                    cmd.mid_capture = 1'b1;
                    cmd.iter_inc    = 1'b1;
                    state_next      = ST_SR_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SR_CMP:
            begin
                if (status.cmp_eq)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (status.cmp_lt)
                begin
                    cmd.lo_up  = 1'b1;
                    state_next = ST_SR_ISSUE;
                end
                else
                begin
                    cmd.hi_down = 1'b1;
                    state_next  = ST_SR_ISSUE;
                end
            end
            ST_INS_ISSUE:
            begin
                if (status.pos_zero)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = stsu_pkg::WR_KEY;
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = stsu_pkg::RD_POS_M1;
                    state_next = ST_INS_STEP;
                end
            end
            ST_INS_STEP:
            begin
                // read data holds the entry just below pos
                if (status.cmp_gt)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = stsu_pkg::WR_DATA;
                    cmd.pos_dec  = 1'b1;
                    cmd.iter_inc = 1'b1;
                    if (status.pos_one)
                    begin
                        state_next = ST_INS_ISSUE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = stsu_pkg::RD_POS_M2;
                    end
                end
                else
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = stsu_pkg::WR_KEY;
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_RM_ISSUE:
            begin
                if (status.pos_lt_count)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = stsu_pkg::RD_POS;
                    state_next = ST_RM_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RM_SCAN:
            begin
                if (status.cmp_eq)
                begin
                    cmd.set_found = 1'b1;
                    if (status.pos1_lt_count)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = stsu_pkg::RD_POS_P1;
                        state_next = ST_RM_SHIFT;
                    end
                    else
                    begin
                        cmd.cnt_dec = 1'b1;
                        state_next  = ST_DONE;
                    end
                end
                else if (status.cmp_lt && status.pos1_lt_count)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = stsu_pkg::RD_POS_P1;
                    cmd.pos_inc = 1'b1;
                end
                else
                begin
                    // past the key in sorted order or end of table: no match
                    state_next = ST_DONE;
                end
            end
            ST_RM_SHIFT:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = stsu_pkg::WR_DATA;
                cmd.pos_inc  = 1'b1;
                cmd.iter_inc = 1'b1;
                if (status.pos2_lt_count)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = stsu_pkg::RD_POS_P2;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/stsu_dp.sv
// Datapath: table memory, count, search bounds, position/iteration counters, output register.
// Depends on stsu_pkg for the command and status structs and field widths.
`default_nettype none

module stsu_dp #(
    parameter int CAPACITY = stsu_pkg::CAPACITY_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire stsu_pkg::cmd_t                      cmd,
    output stsu_pkg::status_t                        status,
    input  wire logic [stsu_pkg::OP_W-1:0]           in_operation,
    input  wire logic signed [stsu_pkg::VALUE_W-1:0] in_value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [stsu_pkg::COUNT_OUT_W-1:0]         out_iterations,
    output logic                                     out_found,
    output logic                                     out_dropped,
    output logic [stsu_pkg::COUNT_OUT_W-1:0]         out_entry_count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W  = CNT_W + 1;

    logic signed [stsu_pkg::VALUE_W-1:0] mem [CAPACITY];
    logic signed [stsu_pkg::VALUE_W-1:0] rd_data_reg;
    logic signed [stsu_pkg::VALUE_W-1:0] key_reg;
    logic [stsu_pkg::OP_W-1:0]           op_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] iter_reg, iter_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi1_reg, hi1_next;   // exclusive upper bound
    logic [CNT_W-1:0] mid_reg;
    logic             found_reg, found_next;
    logic             dropped_reg, dropped_next;
    logic             out_valid_reg, out_valid_next;

    logic [stsu_pkg::COUNT_OUT_W-1:0] out_iter_reg;
    logic [stsu_pkg::COUNT_OUT_W-1:0] out_count_reg;
    logic                             out_found_reg;
    logic                             out_dropped_reg;

    logic [SUM_W-1:0]  mid_sum;
    logic [CNT_W-1:0]  mid;
    logic [SUM_W-1:0]  rd_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic signed [stsu_pkg::VALUE_W-1:0] wr_data;
    logic              full;
    logic              is_insert;

    function automatic logic [stsu_pkg::COUNT_OUT_W-1:0] sat7(input logic [CNT_W-1:0] x);
        logic [31:0] wide;
        wide = 32'(x);
        return (wide > 32'(stsu_pkg::SAT_MAX)) ? stsu_pkg::COUNT_OUT_W'(stsu_pkg::SAT_MAX)
                                               : stsu_pkg::COUNT_OUT_W'(x);
    endfunction

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign is_insert = (in_operation == stsu_pkg::OP_INSERT);

    // floor((lo + hi) / 2) with hi = hi1 - 1; only used while lo < hi1
    assign mid_sum = SUM_W'(lo_reg) + SUM_W'(hi1_reg) - SUM_W'(1);
    assign mid     = mid_sum[CNT_W:1];

    always_comb
    begin
        case (cmd.rd_sel)
            stsu_pkg::RD_MID:    rd_idx = SUM_W'(mid);
            stsu_pkg::RD_POS:    rd_idx = SUM_W'(pos_reg);
            stsu_pkg::RD_POS_M1: rd_idx = SUM_W'(pos_reg) - SUM_W'(1);
            stsu_pkg::RD_POS_M2: rd_idx = SUM_W'(pos_reg) - SUM_W'(2);
            stsu_pkg::RD_POS_P1: rd_idx = SUM_W'(pos_reg) + SUM_W'(1);
            stsu_pkg::RD_POS_P2: rd_idx = SUM_W'(pos_reg) + SUM_W'(2);
            default:             rd_idx = SUM_W'(pos_reg);
        endcase
    end

    assign rd_addr = rd_idx[ADDR_W-1:0];
    assign wr_addr = pos_reg[ADDR_W-1:0];
    assign wr_data = (cmd.wr_sel == stsu_pkg::WR_DATA) ? rd_data_reg : key_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= in_value;
            op_reg  <= in_operation;
        end
        if (cmd.mid_capture)
        begin
            mid_reg <= mid;
        end
        if (cmd.out_load)
        begin
            out_iter_reg    <= sat7(iter_reg);
            out_count_reg   <= sat7(count_reg);
            out_found_reg   <= found_reg;
            out_dropped_reg <= dropped_reg;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        iter_next      = iter_reg;
        lo_next        = lo_reg;
        hi1_next       = hi1_reg;
        found_next     = found_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load)
        begin
            pos_next     = is_insert ? count_reg : '0;
            iter_next    = (is_insert && !full) ? CNT_W'(1) : '0;
            lo_next      = '0;
            hi1_next     = count_reg;
            found_next   = 1'b0;
            dropped_next = is_insert && full;
        end
        if (cmd.pos_inc)
        begin
            pos_next = pos_reg + CNT_W'(1);
        end
        if (cmd.pos_dec)
        begin
            pos_next = pos_reg - CNT_W'(1);
        end
        if (cmd.iter_inc)
        begin
            iter_next = iter_reg + CNT_W'(1);
        end
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.set_found)
        begin
            found_next = 1'b1;
        end
        if (cmd.lo_up)
        begin
            lo_next = mid_reg + CNT_W'(1);
        end
        if (cmd.hi_down)
        begin
            hi1_next = mid_reg;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            iter_reg      <= '0;
            lo_reg        <= '0;
            hi1_reg       <= '0;
            found_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            iter_reg      <= iter_next;
            lo_reg        <= lo_next;
            hi1_reg       <= hi1_next;
            found_reg     <= found_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        status.op            = op_reg;
        status.full          = full;
        status.search_open   = (lo_reg < hi1_reg);
        status.cmp_eq        = (rd_data_reg == key_reg);
        status.cmp_lt        = (rd_data_reg < key_reg);
        status.cmp_gt        = (rd_data_reg > key_reg);
        status.pos_zero      = (pos_reg == '0);
        status.pos_one       = (pos_reg == CNT_W'(1));
        status.pos_lt_count  = (pos_reg < count_reg);
        status.pos1_lt_count = ((SUM_W'(pos_reg) + SUM_W'(1)) < SUM_W'(count_reg));
        status.pos2_lt_count = ((SUM_W'(pos_reg) + SUM_W'(2)) < SUM_W'(count_reg));
        status.out_busy      = out_valid_reg && !out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign out_iterations  = out_iter_reg;
    assign out_found       = out_found_reg;
    assign out_dropped     = out_dropped_reg;
    assign out_entry_count = out_count_reg;

endmodule

`default_nettype wire

// File: design/sorted_table_insert_remove_search_unit.sv
// Sorted table unit: ascending table of signed 32-bit keys with search, insert and remove.
//
// Channels: req (sink) carries operation and value; rsp (source) carries iterations,
// found, dropped and entry_count. A transaction completes when valid and ready are high
// at a rising edge of clk. Every request yields exactly one response, in order.
// One request is worked on at a time; req.ready is high only while the unit is idle.
// Per operation:
//   search: one binary-search probe after another, bounded by the registered memory read
//           feeding each compare
//   insert: one entry moved per cycle through the single memory read/write port pair
//   remove: a scan for the key, then a shift of the entries above it, again one entry per cycle
// The next request is taken in the cycle the previous response turns valid.
// The response sits in an output register: the next request is taken while it waits,
// and a stalled receiver only holds the unit once a second response is ready.
// Reset (rst_n, asynchronous, active low) empties the table by clearing the count;
// table memory is not cleared, entries at or above the count are never read.
`default_nettype none

module sorted_table_insert_remove_search_unit #(
    parameter int CAPACITY = stsu_pkg::CAPACITY_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    stsu_req_if.sink   req,
    stsu_rsp_if.source rsp
);

    stsu_pkg::cmd_t    cmd;
    stsu_pkg::status_t status;
    logic              in_ready;

    assign req.ready = in_ready;

    stsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    stsu_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_operation    (req.operation),
        .in_value        (req.value),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_iterations  (rsp.iterations),
        .out_found       (rsp.found),
        .out_dropped     (rsp.dropped),
        .out_entry_count (rsp.entry_count)
    );

`ifndef ASSERT_OFF
    // an accepted request keeps the unit busy on the following cycle
    assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> !req.ready)
        else $error("request accepted while previous one still in progress");

    // the table never grows past its capacity
    assert property (@(posedge clk) disable iff (!rst_n) cmd.cnt_inc |-> !status.full)
        else $error("insert on a full table");

    // a response is loaded only into a free or draining output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp.valid || rsp.ready))
        else $error("response overwritten before it was taken");

    // insert never reports a match, so found and dropped are exclusive
    assert property (@(posedge clk) disable iff (!rst_n) rsp.valid |-> !(rsp.found && rsp.dropped))
        else $error("found and dropped both set");
`endif

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the sorted table unit: tracks the table in a local copy and
// checks every response, field by field. Needs stsu_pkg, stsu_req_if, stsu_rsp_if, RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int CAP           = stsu_pkg::CAPACITY_DEF;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 2 * CAP + 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 860;

    // code 3 is not decoded by the unit
    localparam logic [stsu_pkg::OP_W-1:0] OP_NONE = 2'd3;

    typedef enum int {
        BIAS_GROW,
        BIAS_SHRINK,
        BIAS_EVEN
    } bias_t;

    typedef struct packed {
        logic [stsu_pkg::COUNT_OUT_W-1:0] iterations;
        logic                             found;
        logic                             dropped;
        logic [stsu_pkg::COUNT_OUT_W-1:0] entry_count;
    } rsp_fields_t;

    logic clk = 1'b0;
    logic rst_n;

    stsu_req_if req_ch ();
    stsu_rsp_if rsp_ch ();

    sorted_table_insert_remove_search_unit #(
        .CAPACITY (CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // local copy of the sorted table
    logic signed [stsu_pkg::VALUE_W-1:0] table_vals [CAP];
    int                                  table_len = 0;
    rsp_fields_t                         pending_q [$];

    int error_count    = 0;
    int items_sent     = 0;
    int responses_seen = 0;
    int hits_seen      = 0;
    int drops_seen     = 0;
    int cycle_count    = 0;
    int burst_left     = 0;

    // long receiver hold-off, requested by a test and counted down by the ready process
    int hold_len  = 0;
    int hold_seq  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    logic [15:0] stall_mask  = 16'hFFFF;
    int          stall_phase = 0;

    rsp_fields_t got_rsp;
    rsp_fields_t want_rsp;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TIMEOUT after %0d cycles, %0d responses pending", cycle_count,
                     pending_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: stall pattern from a mask that is reshuffled once all its bits have been used
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= stall_mask[stall_phase];
            if (stall_phase == 15)
            begin
                stall_phase = 0;
                if ($urandom_range(0, 3) == 0)
                    stall_mask = 16'hFFFF;
                else
                    stall_mask = 16'($urandom) | 16'h0101;
            end
            else
            begin
                stall_phase++;
            end
        end
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_rsp = {rsp_ch.iterations, rsp_ch.found, rsp_ch.dropped, rsp_ch.entry_count};
            responses_seen++;
            if (pending_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: unexpected response it=%0d f=%0b d=%0b cnt=%0d",
                             got_rsp.iterations, got_rsp.found, got_rsp.dropped,
                             got_rsp.entry_count);
            end
            else
            begin
                want_rsp = pending_q.pop_front();
                if (got_rsp !== want_rsp)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"ERROR: response %0d expected it=%0d f=%0b d=%0b cnt=%0d",
                                  " got it=%0d f=%0b d=%0b cnt=%0d"},
                                 responses_seen, want_rsp.iterations, want_rsp.found,
                                 want_rsp.dropped, want_rsp.entry_count, got_rsp.iterations,
                                 got_rsp.found, got_rsp.dropped, got_rsp.entry_count);
                end
                hits_seen  += want_rsp.found;
                drops_seen += want_rsp.dropped;
            end
        end
    end

    // Applies one operation to the local table and returns the response it must produce.
    function automatic rsp_fields_t table_update(
        input logic [stsu_pkg::OP_W-1:0] op,
        input logic signed [stsu_pkg::VALUE_W-1:0] key);
        rsp_fields_t r;
        int lo;
        int hi;
        int mid;
        int pos;
        int steps;
        r     = '0;
        steps = 0;
        case (op)
            stsu_pkg::OP_SEARCH:
            begin
                lo = 0;
                hi = table_len - 1;
                while (lo <= hi)
                begin
                    mid = (lo + hi) / 2;
                    steps++;
                    if (table_vals[mid] == key)
                    begin
                        r.found = 1'b1;
                        break;
                    end
                    else if (table_vals[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
            end
            stsu_pkg::OP_INSERT:
            begin
                if (table_len >= CAP)
                begin
                    r.dropped = 1'b1;
                end
                else
                begin
                    // lands after any equal entries
                    pos = table_len;
                    while (pos > 0 && table_vals[pos-1] > key)
                    begin
                        table_vals[pos] = table_vals[pos-1];
                        pos--;
                    end
                    table_vals[pos] = key;
                    steps = table_len - pos + 1;
                    table_len++;
                end
            end
            stsu_pkg::OP_REMOVE:
            begin
                pos = 0;
                while (pos < table_len && table_vals[pos] != key)
                    pos++;
                if (pos < table_len)
                begin
                    for (int j = pos; j + 1 < table_len; j++)
                        table_vals[j] = table_vals[j+1];
                    steps = table_len - 1 - pos;
                    table_len--;
                    r.found = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.iterations  = stsu_pkg::COUNT_OUT_W'((steps > stsu_pkg::SAT_MAX) ?
                                               stsu_pkg::SAT_MAX : steps);
        r.entry_count = stsu_pkg::COUNT_OUT_W'((table_len > stsu_pkg::SAT_MAX) ?
                                               stsu_pkg::SAT_MAX : table_len);
        return r;
    endfunction

    // Keys: extremes, a narrow band that collides often, stored entries, and full range.
    function automatic logic signed [stsu_pkg::VALUE_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5, 6: return $signed($urandom_range(0, 15)) - 8;
            7:
            begin
                if (table_len > 0)
                    return table_vals[$urandom_range(0, table_len - 1)];
                else
                    return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    // One request transaction; the sender may idle between bursts of random length.
    task automatic send_item(input logic [stsu_pkg::OP_W-1:0] op,
                             input logic signed [stsu_pkg::VALUE_W-1:0] key);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            else if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(5, 30);
            else
                gap = $urandom_range(1, 4);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= key;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_q.push_back(table_update(op, key));
        items_sent++;
        burst_left--;
    endtask

    // Sender pauses until every outstanding response is back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_q.size() != 0);
    endtask

    task automatic test_empty_table();
        send_item(stsu_pkg::OP_SEARCH, 32'sd0);
        send_item(stsu_pkg::OP_SEARCH, 32'sh80000000);
        send_item(stsu_pkg::OP_REMOVE, 32'sh7FFFFFFF);
        send_item(OP_NONE, 32'sd0);
        send_item(stsu_pkg::OP_SEARCH, 32'sh7FFFFFFF);
        wait_drained();
    endtask

    task automatic test_extremes();
        send_item(stsu_pkg::OP_INSERT, 32'sh7FFFFFFF);
        send_item(stsu_pkg::OP_INSERT, 32'sh80000000);
        send_item(stsu_pkg::OP_INSERT, 32'sd0);
        send_item(stsu_pkg::OP_INSERT, -32'sd1);
        send_item(stsu_pkg::OP_INSERT, 32'sh7FFFFFFF);
        send_item(stsu_pkg::OP_INSERT, 32'sd0);
        send_item(stsu_pkg::OP_SEARCH, 32'sh80000000);
        send_item(stsu_pkg::OP_SEARCH, 32'sh7FFFFFFF);
        send_item(stsu_pkg::OP_SEARCH, 32'sd0);
        send_item(stsu_pkg::OP_SEARCH, 32'sd5);
        send_item(stsu_pkg::OP_SEARCH, -32'sd7);
        send_item(stsu_pkg::OP_REMOVE, 32'sd0);
        send_item(stsu_pkg::OP_REMOVE, 32'sd12345);
        send_item(OP_NONE, 32'shFFFFFFFF);
        send_item(stsu_pkg::OP_REMOVE, 32'sh80000000);
        send_item(stsu_pkg::OP_REMOVE, 32'sh7FFFFFFF);
        send_item(stsu_pkg::OP_SEARCH, 32'sh7FFFFFFF);
        send_item(stsu_pkg::OP_INSERT, 32'sd1);
        wait_drained();
    endtask

    // Fill to capacity, push inserts into a full table, then empty it again.
    task automatic test_full_table();
        while (table_len < CAP)
            send_item(stsu_pkg::OP_INSERT, pick_key());
        repeat (4) send_item(stsu_pkg::OP_INSERT, pick_key());
        send_item(stsu_pkg::OP_SEARCH, table_vals[$urandom_range(0, CAP - 1)]);
        send_item(stsu_pkg::OP_SEARCH, pick_key());
        send_item(OP_NONE, pick_key());
        send_item(stsu_pkg::OP_REMOVE, table_vals[$urandom_range(0, CAP - 1)]);
        send_item(stsu_pkg::OP_INSERT, 32'sh80000000);
        send_item(stsu_pkg::OP_INSERT, 32'sh7FFFFFFF);
        while (table_len > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(stsu_pkg::OP_REMOVE, $urandom);
            else
                send_item(stsu_pkg::OP_REMOVE, table_vals[$urandom_range(0, table_len - 1)]);
        end
        send_item(stsu_pkg::OP_SEARCH, pick_key());
        send_item(stsu_pkg::OP_REMOVE, pick_key());
        wait_drained();
    endtask

    task automatic test_random_mix(input int n);
        bias_t bias;
        int r;
        int ins_pct;
        int rem_pct;
        logic [stsu_pkg::OP_W-1:0] op;
        logic signed [stsu_pkg::VALUE_W-1:0] key;
        bias = BIAS_EVEN;
        for (int i = 0; i < n; i++)
        begin
            if (i % 100 == 0)
                bias = bias_t'($urandom_range(0, 2));
            ins_pct = (bias == BIAS_GROW) ? 60 : (bias == BIAS_SHRINK) ? 20 : 35;
            rem_pct = (bias == BIAS_GROW) ? 15 : (bias == BIAS_SHRINK) ? 55 : 35;
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_NONE;
            else if (r < 3 + ins_pct)
                op = stsu_pkg::OP_INSERT;
            else if (r < 3 + ins_pct + rem_pct)
                op = stsu_pkg::OP_REMOVE;
            else
                op = stsu_pkg::OP_SEARCH;
            if (op != stsu_pkg::OP_INSERT && table_len > 0 && $urandom_range(0, 1) == 1)
                key = table_vals[$urandom_range(0, table_len - 1)];
            else
                key = pick_key();
            send_item(op, key);
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering: the unit fills and stalls.
    task automatic test_backpressure();
        hold_len = HOLD_CYCLES;
        hold_seq++;
        burst_left = 1000;
        repeat (4) send_item(stsu_pkg::OP_INSERT, pick_key());
        repeat (3) send_item(stsu_pkg::OP_SEARCH, pick_key());
        repeat (3) send_item(stsu_pkg::OP_REMOVE, pick_key());
        wait_drained();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = stsu_pkg::OP_SEARCH;
        req_ch.value     = '0;
        rsp_ch.ready     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_extremes();
        test_full_table();
        test_backpressure();
        test_random_mix(RANDOM_ITEMS);
        test_backpressure();

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run: %0d request transactions, %0d responses checked, %0d matches, %0d drops",
                 items_sent, responses_seen, hits_seen, drops_seen);
        $display("Covered empty and full table, extreme keys, duplicates, unused opcode, stalls");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
design/stsu_pkg.sv
design/stsu_req_if.sv
design/stsu_rsp_if.sv
design/stsu_ctrl.sv
design/stsu_dp.sv
design/sorted_table_insert_remove_search_unit.sv
bench/tb_top.sv
